>>> hdl/c3d_pkg.sv
// ----------------------------------------------------------------------------
// c3d_pkg
// Shared types and constants of the 3x3x3 int16 volume convolution.
// ----------------------------------------------------------------------------
package c3d_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_SLICES = 1024;
    localparam int W_BITS     = $clog2(MAX_WIDTH);
    localparam int S_BITS     = $clog2(MAX_SLICES);
    localparam int TAPS       = 27;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic FUNC_COEFF = 1'b0;
    localparam logic FUNC_VOXEL = 1'b1;

    typedef enum logic [1:0] {
        CFG_LINE_WIDTH  = 2'd0,
        CFG_SLICE_COUNT = 2'd1,
        CFG_NORM_SHIFT  = 2'd2,
        CFG_SAT_MODE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               func;
        logic [4:0]         coeff_index;
        logic signed [31:0] coeff_value;
        logic signed [15:0] voxel;
    } t_in;

    typedef struct packed {
        logic signed [15:0] result;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [7:0]  line_width;
        logic [10:0] slice_count;
        logic [4:0]  norm_shift;
        logic        saturate_mode;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic last;
    } t_win_ctl;

    typedef logic signed [15:0] t_sample;
    // column index kz*3+ky, window index kz*9+ky*3+kx
    typedef t_sample [8:0]      t_col;
    typedef t_sample [TAPS-1:0] t_window;

endpackage

>>> hdl/c3d_window.sv
// ----------------------------------------------------------------------------
// c3d_window
// Voxel position counters, slice and line stores, and the 3x3x3 window.
// ----------------------------------------------------------------------------
module c3d_window import c3d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_restart,
    input  logic     i_vox_req,
    input  t_sample  i_voxel,
    output logic     o_emit,
    output t_win_ctl o_win_ctl,
    output t_window  o_window
);

    logic [W_BITS-1:0] r_col, r_row, n_col, n_row;
    logic [S_BITS-1:0] r_slc, n_slc;
    logic              n_last;

    // slice store word: {slice s-1, slice s-2}; line store word: {row r-1, row r-2}
    logic [31:0] plane_mem [MAX_WIDTH*MAX_WIDTH];
    logic [95:0] line_mem  [MAX_WIDTH];
    logic [31:0] r_plane_q;
    logic [95:0] r_line_q;

    logic                r_v1, r_emit1, r_last1;
    t_sample             r_vox1;
    logic [2*W_BITS-1:0] r_addr1;
    logic [W_BITS-1:0]   r_c1;
    t_col                r_cm1, r_cm2, cur;
    logic [47:0]         cur48;

    assign o_emit = (r_slc >= S_BITS'(2)) && (r_row >= W_BITS'(2)) && (r_col >= W_BITS'(2));
    assign n_last = ({1'b0, r_slc} == i_cfg.slice_count - 11'd1)
                 && ({1'b0, r_row} == i_cfg.line_width - 8'd1)
                 && ({1'b0, r_col} == i_cfg.line_width - 8'd1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_slc = r_slc;
        if (({1'b0, r_col} + 8'd1) < i_cfg.line_width) begin
            n_col = r_col + W_BITS'(1);
        end else begin
            n_col = '0;
            if (({1'b0, r_row} + 8'd1) < i_cfg.line_width) begin
                n_row = r_row + W_BITS'(1);
            end else begin
                n_row = '0;
                n_slc = (({1'b0, r_slc} + 11'd1) < i_cfg.slice_count)
                      ? r_slc + S_BITS'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_slc <= '0;
        end else if (i_vox_req) begin
            r_col <= n_col;
            r_row <= n_row;
            r_slc <= n_slc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_emit1 <= 1'b0;
        end else begin
            r_v1    <= i_vox_req;
            r_emit1 <= i_vox_req && o_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vox_req) begin
            r_plane_q <= plane_mem[{r_row, r_col}];
            r_line_q  <= line_mem[r_col];
            r_vox1    <= i_voxel;
            r_last1   <= n_last;
            r_addr1   <= {r_row, r_col};
            r_c1      <= r_col;
        end
        if (r_v1) begin
            plane_mem[r_addr1] <= {r_vox1, r_plane_q[31:16]};
            line_mem[r_c1]     <= {cur48, r_line_q[95:48]};
            r_cm1 <= cur;
            r_cm2 <= r_cm1;
        end
    end

    assign cur48 = {r_vox1, r_plane_q};

    always_comb begin
        for (int kz = 0; kz < 3; kz++) begin
            cur[kz*3+2] = cur48[kz*16 +: 16];
            cur[kz*3+1] = r_line_q[48 + kz*16 +: 16];
            cur[kz*3+0] = r_line_q[kz*16 +: 16];
        end
        for (int j = 0; j < 9; j++) begin
            o_window[(j/3)*9 + (j%3)*3 + 0] = r_cm2[j];
            o_window[(j/3)*9 + (j%3)*3 + 1] = r_cm1[j];
            o_window[(j/3)*9 + (j%3)*3 + 2] = cur[j];
        end
    end

    assign o_win_ctl.valid = r_emit1;
    assign o_win_ctl.last  = r_last1;

endmodule

>>> hdl/c3d_mac.sv
// ----------------------------------------------------------------------------
// c3d_mac
// Kernel table, 27 products, registered adder tree, shift and optional clip.
// ----------------------------------------------------------------------------
module c3d_mac import c3d_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_coeff_we,
    input  logic [4:0]         i_coeff_index,
    input  logic signed [31:0] i_coeff_value,
    input  t_win_ctl           i_win_ctl,
    input  t_window            i_window,
    output logic               o_res_valid,
    output t_out               o_res
);

    logic [31:0] r_coef [TAPS];
    logic [31:0] r_prod [TAPS];
    logic [31:0] n_prod [TAPS];
    logic [31:0] r_s9   [9];
    logic [31:0] r_s3   [3];
    logic [31:0] r_sum;
    logic [3:0]  r_v, r_last;
    logic signed [31:0] shifted;
    logic signed [47:0] full [TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) r_coef[k] <= '0;
        end else if (i_coeff_we && (i_coeff_index < 5'(TAPS))) begin
            r_coef[i_coeff_index] <= i_coeff_value;
        end
    end

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            full[k]   = 48'(i_window[k]) * 48'($signed(r_coef[k]));
            n_prod[k] = full[k][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_win_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[2:0], i_win_ctl.last};
        for (int k = 0; k < TAPS; k++) r_prod[k] <= n_prod[k];
        for (int g = 0; g < 9; g++) r_s9[g] <= r_prod[3*g] + r_prod[3*g+1] + r_prod[3*g+2];
        for (int g = 0; g < 3; g++) r_s3[g] <= r_s9[3*g] + r_s9[3*g+1] + r_s9[3*g+2];
        r_sum <= r_s3[0] + r_s3[1] + r_s3[2];
    end

    assign shifted = $signed(r_sum) >>> i_cfg.norm_shift;

    always_comb begin
        o_res.result = shifted[15:0];
        if (i_cfg.saturate_mode) begin
            if (shifted < -32'sd32768)     o_res.result = 16'sh8000;
            else if (shifted > 32'sd32767) o_res.result = 16'sh7fff;
        end
    end

    assign o_res.last  = r_last[3];
    assign o_res_valid = r_v[3];

endmodule

>>> hdl/c3d_fifo.sv
// ----------------------------------------------------------------------------
// c3d_fifo
// Small result queue between the arithmetic pipeline and the output channel.
// ----------------------------------------------------------------------------
module c3d_fifo import c3d_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    input  logic i_stall,
    output logic o_valid,
    output t_out o_data
);

    t_out               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + FIFO_AW'(1);
            if (pop)    r_rp <= r_rp + FIFO_AW'(1);
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(pop);
        end
    end

endmodule

>>> hdl/conv3d_3x3x3_int16_top.sv
// each result passes the window, product, partial-sum, total and queue registers
// throughput: one request per cycle while o_stall is low, coefficient or voxel,
//   set by the single slice store read and write port pair used once per voxel
// input stalls only while 8 results are queued or in flight
// reset: synchronous active low; counters, queue and kernel cleared, geometry 128x128x128
// slice store contents are left as they are and need no clearing pass
module conv3d_3x3x3_int16_top import c3d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in      i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out     o_data,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic [FIFO_AW:0] r_pend;
    logic             acc, vox_req, coeff_we, emit, cfg_we, restart, res_valid, pop;
    t_win_ctl         win_ctl;
    t_window          window;
    t_out             res;

    assign o_cfg_ready = 1'b1;
    assign cfg_we   = i_cfg_valid;
    assign restart  = cfg_we && (i_cfg_index == CFG_LINE_WIDTH
                              || i_cfg_index == CFG_SLICE_COUNT);
    assign o_stall  = (r_pend == (FIFO_AW+1)'(FIFO_DEPTH));
    assign acc      = i_valid && !o_stall;
    assign vox_req  = acc && (i_data.func == FUNC_VOXEL);
    assign coeff_we = acc && (i_data.func == FUNC_COEFF);
    assign pop      = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width    <= 8'd128;
            r_cfg.slice_count   <= 11'd128;
            r_cfg.norm_shift    <= '0;
            r_cfg.saturate_mode <= 1'b0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH: begin
                    if (i_cfg_data[7:0] < 8'd3)
                        r_cfg.line_width <= 8'd3;
                    else if (i_cfg_data[7:0] > 8'(MAX_WIDTH))
                        r_cfg.line_width <= 8'(MAX_WIDTH);
                    else
                        r_cfg.line_width <= i_cfg_data[7:0];
                end
                CFG_SLICE_COUNT: begin
                    if (i_cfg_data[10:0] < 11'd3)
                        r_cfg.slice_count <= 11'd3;
                    else if (i_cfg_data[10:0] > 11'(MAX_SLICES))
                        r_cfg.slice_count <= 11'(MAX_SLICES);
                    else
                        r_cfg.slice_count <= i_cfg_data[10:0];
                end
                CFG_NORM_SHIFT: r_cfg.norm_shift    <= i_cfg_data[4:0];
                CFG_SAT_MODE:   r_cfg.saturate_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // results requested but not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + (FIFO_AW+1)'(vox_req && emit) - (FIFO_AW+1)'(pop);
        end
    end

    c3d_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (restart),
        .i_vox_req (vox_req),
        .i_voxel   (i_data.voxel),
        .o_emit    (emit),
        .o_win_ctl (win_ctl),
        .o_window  (window)
    );

    c3d_mac u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_coeff_we    (coeff_we),
        .i_coeff_index (i_data.coeff_index),
        .i_coeff_value (i_data.coeff_value),
        .i_win_ctl     (win_ctl),
        .i_window      (window),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    c3d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("pending result count above queue depth");

    a_out_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != '0)
        else $error("result shown with nothing pending");

    a_push_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> r_pend != '0)
        else $error("pipeline result without a pending request");

endmodule

>>> verif/conv3d_3x3x3_int16_top_tb.sv
// ----------------------------------------------------------------------------
// conv3d_3x3x3_int16_top_tb
// Streams kernels and small volumes through the convolution with random
// gaps and stalls on both sides. Every accepted request updates a local
// prediction of the filter, and each result is checked against the oldest
// predicted voxel.
// ----------------------------------------------------------------------------
module conv3d_3x3x3_int16_top_tb;
    import c3d_pkg::*;

    localparam int PLANE = MAX_WIDTH * MAX_WIDTH;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [15:0] i_cfg_data;

    conv3d_3x3x3_int16_top i_dut (.*);

    // filter state as seen by the predictor
    logic signed [15:0] vol_store [3*PLANE];
    logic signed [31:0] kernel [TAPS];
    int unsigned        cur_col, cur_row, cur_slice;
    int unsigned        width, depth, shift_amt;
    bit                 sat_on;

    t_out  pending_voxels [$];
    int    fail_count;
    bit    no_idle;
    int    hold_cycles;
    int    stall_run;
    bit    stall_state;
    int    item_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 500000);
        $display("conv3d_3x3x3_int16_top test failed");
        $finish;
    end

    function automatic int unsigned store_addr(int unsigned s, int unsigned r, int unsigned c);
        return (s % 3) * PLANE + r * MAX_WIDTH + c;
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic filter_reset();
        foreach (kernel[k]) kernel[k] = '0;
        cur_col = 0;
        cur_row = 0;
        cur_slice = 0;
        width = MAX_WIDTH;
        depth = 128;
        shift_amt = 0;
        sat_on = 1'b0;
    endtask

    task automatic filter_config(t_cfg_idx idx, logic [15:0] val);
        case (idx)
            CFG_LINE_WIDTH: begin
                width = clamp(val[7:0], 3, MAX_WIDTH);
                cur_col = 0; cur_row = 0; cur_slice = 0;
            end
            CFG_SLICE_COUNT: begin
                depth = clamp(val[10:0], 3, MAX_SLICES);
                cur_col = 0; cur_row = 0; cur_slice = 0;
            end
            CFG_NORM_SHIFT: shift_amt = val[4:0];
            CFG_SAT_MODE:   sat_on = val[0];
            default: ;
        endcase
    endtask

    // applies one accepted request and queues the voxel it completes, if any
    task automatic filter_step(t_in it);
        logic signed [31:0] acc;
        logic signed [31:0] prod;
        logic signed [31:0] scaled;
        t_out               exp_out;
        if (it.func == FUNC_COEFF) begin
            if (it.coeff_index < TAPS) kernel[it.coeff_index] = it.coeff_value;
            return;
        end
        vol_store[store_addr(cur_slice, cur_row, cur_col)] = it.voxel;
        if (cur_slice >= 2 && cur_row >= 2 && cur_col >= 2) begin
            acc = '0;
            for (int kz = 0; kz < 3; kz++)
                for (int ky = 0; ky < 3; ky++)
                    for (int kx = 0; kx < 3; kx++) begin
                        prod = vol_store[store_addr(cur_slice - 2 + kz, cur_row - 2 + ky,
                                                    cur_col - 2 + kx)] * kernel[kz*9 + ky*3 + kx];
                        acc = acc + prod;
                    end
            scaled = acc >>> shift_amt;
            if (sat_on && scaled > 32767)        exp_out.result = 16'sh7fff;
            else if (sat_on && scaled < -32768)  exp_out.result = 16'sh8000;
            else                                 exp_out.result = scaled[15:0];
            exp_out.last = (cur_slice == depth - 1 && cur_row == width - 1
                            && cur_col == width - 1);
            pending_voxels.push_back(exp_out);
        end
        if (cur_col + 1 < width) cur_col++;
        else begin
            cur_col = 0;
            if (cur_row + 1 < width) cur_row++;
            else begin
                cur_row = 0;
                cur_slice = (cur_slice + 1 < depth) ? cur_slice + 1 : 0;
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_voxels.size() == 0) begin
                $error("unexpected result %0d last %0b", o_data.result, o_data.last);
                fail_count++;
            end else begin
                t_out exp_out;
                exp_out = pending_voxels.pop_front();
                if (o_data.result !== exp_out.result) begin
                    $error("result: expected %0d actual %0d", exp_out.result, o_data.result);
                    fail_count++;
                end
                if (o_data.last !== exp_out.last) begin
                    $error("last: expected %0b actual %0b", exp_out.last, o_data.last);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls: random bursts, long hold-offs on request, none at the end
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_state = $urandom_range(0, 2) == 0;
                stall_run = $urandom_range(1, 18);
                if (!stall_state && $urandom_range(0, 3) == 0) stall_run = 60;
            end
            stall_run--;
            i_stall <= stall_state;
        end
    end

    task automatic idle_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic send_request(t_in it);
        if (!no_idle && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 18));
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        filter_step(it);
        item_count++;
    endtask

    // waits until every predicted voxel is out and the pipeline is empty
    task automatic drain();
        int guard;
        idle_gap(1);
        guard = 0;
        while (pending_voxels.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [15:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        filter_config(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in coeff_req(logic [4:0] idx, logic signed [31:0] val);
        t_in it;
        it.func = FUNC_COEFF;
        it.coeff_index = idx;
        it.coeff_value = val;
        it.voxel = 16'($urandom);
        return it;
    endfunction

    function automatic t_in voxel_req(logic signed [15:0] v);
        t_in it;
        it.func = FUNC_VOXEL;
        it.coeff_index = 5'($urandom);
        it.coeff_value = $urandom;
        it.voxel = v;
        return it;
    endfunction

    function automatic logic signed [15:0] rand_voxel();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_kernel(bit wide);
        for (int k = 0; k < TAPS; k++)
            send_request(coeff_req(5'(k), wide ? 32'($urandom)
                                               : 32'($signed($urandom_range(0, 16)) - 8)));
    endtask

    task automatic stream_volume(int unsigned n_vox, bit mix_coeffs);
        for (int unsigned v = 0; v < n_vox; v++) begin
            if (mix_coeffs && $urandom_range(0, 15) == 0)
                send_request(coeff_req(5'($urandom), $urandom));
            send_request(voxel_req(rand_voxel()));
        end
    endtask

    // extreme kernel words, ignored indexes and a single-window volume
    task automatic test_directed();
        write_register(CFG_LINE_WIDTH, 16'd3);
        write_register(CFG_SLICE_COUNT, 16'd3);
        send_request(coeff_req(5'd27, 32'sh7fffffff));
        send_request(coeff_req(5'd31, 32'sh80000000));
        send_request(coeff_req(5'd0, 32'sh7fffffff));
        send_request(coeff_req(5'd26, 32'sh80000000));
        send_request(coeff_req(5'd13, -32'sd1));
        for (int v = 0; v < 27; v++)
            send_request(voxel_req(v[0] ? 16'sh8000 : 16'sh7fff));
        write_register(CFG_SAT_MODE, 16'd1);
        write_register(CFG_NORM_SHIFT, 16'd31);
        stream_volume(27, 1'b0);
        write_register(CFG_NORM_SHIFT, 16'hffe0);
        stream_volume(27, 1'b0);
    endtask

    // out-of-range geometry saturates, and bits above each field are ignored
    task automatic test_geometry_clamp();
        write_register(CFG_LINE_WIDTH, 16'h0000);
        write_register(CFG_SLICE_COUNT, 16'h0001);
        stream_volume(27, 1'b0);
        write_register(CFG_LINE_WIDTH, 16'hff04);
        write_register(CFG_SLICE_COUNT, 16'hf803);
        stream_volume(48, 1'b0);
    endtask

    task automatic test_random_volumes();
        int unsigned w, s;
        while (item_count < 200) begin
            w = $urandom_range(3, 5);
            s = $urandom_range(3, 4);
            write_register(CFG_LINE_WIDTH, 16'(w) | (16'($urandom) & 16'hff00));
            write_register(CFG_SLICE_COUNT, 16'(s));
            write_register(CFG_NORM_SHIFT, $urandom_range(0, 1) ? 16'($urandom_range(0, 6))
                                                                : 16'($urandom));
            write_register(CFG_SAT_MODE, 16'($urandom));
            load_kernel($urandom_range(0, 2) == 0);
            stream_volume(w * w * s + $urandom_range(0, 1) * $urandom_range(0, 20), 1'b1);
        end
    endtask

    // receiver holds off while requests keep coming, filling the output queue
    task automatic test_backpressure();
        write_register(CFG_LINE_WIDTH, 16'd4);
        write_register(CFG_SLICE_COUNT, 16'd6);
        load_kernel(1'b0);
        @(negedge i_clk);
        hold_cycles = 120;
        no_idle = 1'b1;
        stream_volume(96, 1'b0);
        no_idle = 1'b0;
    endtask

    // widest line and deepest stack, no idling from here on
    task automatic test_large_geometry();
        no_idle = 1'b1;
        write_register(CFG_SAT_MODE, 16'd0);
        write_register(CFG_NORM_SHIFT, 16'd4);
        write_register(CFG_LINE_WIDTH, 16'd128);
        write_register(CFG_SLICE_COUNT, 16'd3);
        stream_volume(40, 1'b0);
        write_register(CFG_LINE_WIDTH, 16'd3);
        write_register(CFG_SLICE_COUNT, 16'd1024);
        stream_volume(45, 1'b0);
    endtask

    initial begin
        fail_count = 0;
        no_idle = 1'b0;
        hold_cycles = 0;
        stall_run = 0;
        item_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LINE_WIDTH;
        i_cfg_data = '0;
        filter_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_geometry_clamp();
        test_random_volumes();
        test_backpressure();
        test_large_geometry();
        drain();

        if (pending_voxels.size() != 0) begin
            $error("%0d results never arrived", pending_voxels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("conv3d_3x3x3_int16_top test passed");
        end else begin
            $display("conv3d_3x3x3_int16_top test failed");
        end
        $finish;
    end

endmodule
